@@ sv/kvr_pkg.sv @@
// Shared types, constants and fixed-point helpers for the kinematic vehicle rollout core.
// No dependencies; compile first.
package kvr_pkg;

    // CORDIC iteration count (12 to 32)
    localparam int CORDIC_ITERATIONS = 24;
    localparam int IT_W              = 5;
    localparam int CFG_IDX_W         = 3;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_STEP_SIZE       = 3'd0,
        CFG_START_POS_X     = 3'd1,
        CFG_START_POS_Y     = 3'd2,
        CFG_START_HEADING   = 3'd3,
        CFG_START_SPEED     = 3'd4,
        CFG_START_ACCEL     = 3'd5,
        CFG_START_CURVATURE = 3'd6
    } t_cfg_idx;

    // Wide working word, multiplier operand and CORDIC datapath word
    typedef logic signed [71:0] t_wide;
    typedef logic signed [34:0] t_mop;
    typedef logic signed [33:0] t_cord;

    typedef struct packed {
        logic signed [31:0] val;
        logic               sat;
    } t_clamp;

    localparam logic [15:0]        STEP_SIZE_RST   = 16'd6554;
    localparam t_cord              CORDIC_GAIN_Q30 = 34'sd652032874;
    localparam logic signed [31:0] TWO_OVER_PI_Q30 = 32'sd683565276;
    localparam t_wide              HALF_PI_Q40     = 72'sd1727108826180;

    // Arctangent of 2^-i in Q2.30
    localparam logic signed [31:0] ATAN_Q30 [32] = '{
        32'sd843314857, 32'sd497837829, 32'sd263043837, 32'sd133525159,
        32'sd67021687,  32'sd33543516,  32'sd16775851,  32'sd8388437,
        32'sd4194283,   32'sd2097149,   32'sd1048576,   32'sd524288,
        32'sd262144,    32'sd131072,    32'sd65536,     32'sd32768,
        32'sd16384,     32'sd8192,      32'sd4096,      32'sd2048,
        32'sd1024,      32'sd512,       32'sd256,       32'sd128,
        32'sd64,        32'sd32,        32'sd16,        32'sd8,
        32'sd4,         32'sd2,         32'sd1,         32'sd0
    };

    // Add half an LSB, then shift with floor (ties toward +inf)
    function automatic t_wide rnd_shift(input t_wide v, input int unsigned s);
        t_wide half;
        half = t_wide'(1) <<< (s - 1);
        return (v + half) >>> s;
    endfunction

    // Clamp to the signed 32 bit range and flag it
    function automatic t_clamp clamp32(input t_wide v);
        t_clamp r;
        if (v > 72'sd2147483647) begin
            r.val = 32'sh7FFFFFFF;
            r.sat = 1'b1;
        end else if (v < -72'sd2147483648) begin
            r.val = 32'sh80000000;
            r.sat = 1'b1;
        end else begin
            r.val = v[31:0];
            r.sat = 1'b0;
        end
        return r;
    endfunction

endpackage

@@ sv/kvr_if.sv @@
// Channel interfaces of the rollout core: step input, result output, configuration writes.
// No dependencies beyond the package order.
interface kvr_in_if;
    logic        valid;
    logic        ready;
    logic        restart;
    logic [31:0] jerk;
    logic [31:0] curvature_rate;

    modport source (output valid, output restart, output jerk, output curvature_rate,
                    input ready);
    modport sink   (input valid, input restart, input jerk, input curvature_rate,
                    output ready);
endinterface

interface kvr_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] next_pos_x;
    logic [31:0] next_pos_y;
    logic [31:0] next_heading;
    logic [31:0] next_speed;
    logic [31:0] next_accel;
    logic [31:0] next_curvature;
    logic        saturated;

    modport source (output valid, output next_pos_x, output next_pos_y, output next_heading,
                    output next_speed, output next_accel, output next_curvature,
                    output saturated, input ready);
    modport sink   (input valid, input next_pos_x, input next_pos_y, input next_heading,
                    input next_speed, input next_accel, input next_curvature,
                    input saturated, output ready);
endinterface

interface kvr_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [31:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

@@ sv/kinematic_vehicle_rollout_core.sv @@
// Top level of the kinematic vehicle rollout core: sequencer, shared multiplier and CORDIC.
// Depends on kvr_pkg and the channel interfaces in kvr_if.sv.
//
// Each accepted transaction advances the vehicle state (x, y, heading, speed,
// acceleration, curvature) by one step of length h and offers the new state as one
// result transaction; restart reloads the state from the start registers first. The block
// takes one step at a time and accepts no new step until the current one has ended. The
// steps are serialised on the single shared 35x35 multiplier, which carries all fourteen
// products one per cycle, and the single CORDIC rotator, which takes the sine and cosine
// of the heading and then of the predicted heading, one micro-rotation per cycle. A
// finished result sits in an output register, so the next step is accepted while it
// waits; the core only holds at the end of a step if the previous result has still not
// been taken. Configuration writes are always taken and must only be issued while no
// step is in flight.
module kinematic_vehicle_rollout_core import kvr_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    kvr_in_if.sink    i_in,
    kvr_out_if.source o_out,
    kvr_cfg_if.sink   i_cfg
);

    typedef enum logic [5:0] {
        S_IDLE    = 6'b000001,
        S_MULS    = 6'b000010,
        S_REDUCE  = 6'b000100,
        S_ROTATE  = 6'b001000,
        S_QUAD    = 6'b010000,
        S_PROJECT = 6'b100000
    } t_state;

    t_state r_state, n_state;
    logic [3:0]      r_op;
    logic [IT_W-1:0] r_it;
    logic            r_sel;
    logic            r_sat;
    logic            r_out_valid;

    // Configuration and vehicle state
    logic [15:0]        r_step_size;
    logic signed [31:0] r_start_px, r_start_py, r_start_th;
    logic signed [31:0] r_start_v, r_start_a, r_start_k;
    logic signed [31:0] r_px, r_py, r_th, r_v, r_a, r_k;

    // Working registers
    logic signed [31:0] r_jerk, r_xi;
    logic signed [69:0] r_p;
    logic signed [50:0] r_hafull;
    logic signed [33:0] r_c1, r_hv, r_hc1;
    logic signed [65:0] r_hvk, r_acc;
    logic signed [31:0] r_c2, r_c3, r_c4, r_v1, r_th1, r_x1, r_y1;
    logic signed [8:0]  r_q;
    t_cord              r_cx, r_sy, r_z;
    t_cord              r_cth, r_sth, r_cc2, r_sc2;

    // Output register
    logic [31:0] r_o_px, r_o_py, r_o_th, r_o_v, r_o_a, r_o_k;
    logic        r_o_sat;

    logic in_fire, cfg_fire, commit;
    t_mop m_a, m_b, h_op;
    t_wide p_w, w_r16, w_q, w_r40, w_z, w_accsum;
    t_clamp w_c3, w_c4, w_c2, w_v1, w_th1, w_x1, w_y1;
    logic signed [31:0] angle;
    t_cord xs, ys, atan_i, q_cos, q_sin;

    assign in_fire    = i_in.valid && i_in.ready;
    assign cfg_fire   = i_cfg.valid && i_cfg.ready;
    assign i_in.ready = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;
    assign commit     = (r_state == S_PROJECT) && (r_op == 4'd4) &&
                        (!r_out_valid || o_out.ready);

    // Shared multiplier operand selection
    assign h_op = $signed({19'd0, r_step_size});
    always_comb begin
        m_a = '0;
        m_b = '0;
        case (r_state)
            S_MULS: begin
                case (r_op)
                    4'd0: begin m_a = h_op; m_b = t_mop'(r_a); end
                    4'd1: begin m_a = h_op; m_b = t_mop'(r_v); end
                    4'd2: begin m_a = h_op; m_b = t_mop'(r_c1); end
                    4'd3: begin m_a = h_op; m_b = t_mop'(r_xi); end
                    4'd4: begin m_a = h_op; m_b = t_mop'(r_jerk); end
                    4'd5: begin m_a = t_mop'(r_hv); m_b = t_mop'(r_k); end
                    4'd6: begin m_a = h_op; m_b = t_mop'(r_c4); end
                    4'd7: begin m_a = t_mop'(r_hc1); m_b = t_mop'(r_c3); end
                    4'd8: begin m_a = t_mop'(r_th); m_b = t_mop'(TWO_OVER_PI_Q30); end
                    default: ;
                endcase
            end
            S_QUAD: begin
                if (!r_sel) begin
                    m_a = t_mop'(r_c2);
                    m_b = t_mop'(TWO_OVER_PI_Q30);
                end else begin
                    m_a = t_mop'(r_hv);
                    m_b = t_mop'(r_cth);
                end
            end
            S_PROJECT: begin
                case (r_op)
                    4'd0: begin m_a = t_mop'(r_hc1); m_b = t_mop'(r_cc2); end
                    4'd1: begin m_a = t_mop'(r_hv); m_b = t_mop'(r_sth); end
                    4'd2: begin m_a = t_mop'(r_hc1); m_b = t_mop'(r_sc2); end
                    default: ;
                endcase
            end
            default: ;
        endcase
    end

    // Datapath terms taken from the registered product
    assign p_w      = t_wide'(r_p);
    assign w_r16    = rnd_shift(p_w, 16);
    assign w_c3     = clamp32(t_wide'(r_k) + w_r16);
    assign w_c4     = clamp32(t_wide'(r_a) + w_r16);
    assign w_c2     = clamp32(t_wide'(r_th) + w_r16);
    assign w_v1     = clamp32(t_wide'(r_v) + rnd_shift(t_wide'(r_hafull) + p_w, 17));
    assign w_th1    = clamp32(t_wide'(r_th) + rnd_shift(t_wide'(r_hvk), 17) +
                              rnd_shift(p_w, 17));
    assign w_q      = rnd_shift(p_w, 54);
    assign angle    = r_sel ? r_c2 : r_th;
    assign w_r40    = (t_wide'(angle) <<< 16) - t_wide'(r_q) * HALF_PI_Q40;
    assign w_z      = rnd_shift(w_r40, 10);
    assign w_accsum = t_wide'(r_acc) + p_w;
    assign w_x1     = clamp32(t_wide'(r_px) + rnd_shift(w_accsum, 31));
    assign w_y1     = clamp32(t_wide'(r_py) + rnd_shift(w_accsum, 31));

    // CORDIC micro-rotation terms
    assign xs     = r_cx >>> r_it;
    assign ys     = r_sy >>> r_it;
    assign atan_i = t_cord'(ATAN_Q30[r_it]);

    // Quadrant rotation of the CORDIC result
    always_comb begin
        case (r_q[1:0])
            2'd0:    begin q_cos = r_cx;  q_sin = r_sy;  end
            2'd1:    begin q_cos = -r_sy; q_sin = r_cx;  end
            2'd2:    begin q_cos = -r_cx; q_sin = -r_sy; end
            default: begin q_cos = r_sy;  q_sin = -r_cx; end
        endcase
    end

    // Sequencer next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:    if (in_fire) n_state = S_MULS;
            S_MULS:    if (r_op == 4'd8) n_state = S_REDUCE;
            S_REDUCE:  if (r_op == 4'd1) n_state = S_ROTATE;
            S_ROTATE:  if (r_it == IT_W'(CORDIC_ITERATIONS - 1)) n_state = S_QUAD;
            S_QUAD:    n_state = r_sel ? S_PROJECT : S_REDUCE;
            S_PROJECT: if (commit) n_state = S_IDLE;
            default:   n_state = S_IDLE;
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_op        <= '0;
            r_it        <= '0;
            r_sel       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            case (r_state)
                S_IDLE: begin
                    r_op  <= '0;
                    r_sel <= 1'b0;
                end
                S_MULS:    r_op <= (r_op == 4'd8) ? 4'd0 : r_op + 4'd1;
                S_REDUCE: begin
                    r_op <= (r_op == 4'd1) ? 4'd0 : r_op + 4'd1;
                    r_it <= '0;
                end
                S_ROTATE:  r_it <= r_it + IT_W'(1);
                S_QUAD: begin
                    r_sel <= 1'b1;
                    r_op  <= '0;
                end
                S_PROJECT: if (r_op != 4'd4) r_op <= r_op + 4'd1;
                default: ;
            endcase
            // Hold the result until taken
            if (commit) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Configuration registers and vehicle state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step_size <= STEP_SIZE_RST;
            r_start_px  <= '0;
            r_start_py  <= '0;
            r_start_th  <= '0;
            r_start_v   <= '0;
            r_start_a   <= '0;
            r_start_k   <= '0;
            r_px        <= '0;
            r_py        <= '0;
            r_th        <= '0;
            r_v         <= '0;
            r_a         <= '0;
            r_k         <= '0;
        end else begin
            if (cfg_fire) begin
                case (t_cfg_idx'(i_cfg.index))
                    CFG_STEP_SIZE:       r_step_size <= i_cfg.data[15:0];
                    CFG_START_POS_X:     r_start_px  <= i_cfg.data;
                    CFG_START_POS_Y:     r_start_py  <= i_cfg.data;
                    CFG_START_HEADING:   r_start_th  <= i_cfg.data;
                    CFG_START_SPEED:     r_start_v   <= i_cfg.data;
                    CFG_START_ACCEL:     r_start_a   <= i_cfg.data;
                    CFG_START_CURVATURE: r_start_k   <= i_cfg.data;
                    default: ;
                endcase
            end
            // Reload the start state ahead of the step
            if (in_fire && i_in.restart) begin
                r_px <= r_start_px;
                r_py <= r_start_py;
                r_th <= r_start_th;
                r_v  <= r_start_v;
                r_a  <= r_start_a;
                r_k  <= r_start_k;
            end
            // Advance the state at the end of the step
            if (commit) begin
                r_px <= r_x1;
                r_py <= r_y1;
                r_th <= r_th1;
                r_v  <= r_v1;
                r_a  <= r_c4;
                r_k  <= r_c3;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        r_p <= m_a * m_b;
        if (in_fire) begin
            r_jerk <= i_in.jerk;
            r_xi   <= i_in.curvature_rate;
            r_sat  <= 1'b0;
        end
        case (r_state)
            S_MULS: begin
                case (r_op)
                    4'd1: begin
                        r_hafull <= p_w[50:0];
                        r_c1     <= t_cord'(t_wide'(r_v) + w_r16);
                    end
                    4'd2: r_hv  <= t_cord'(w_r16);
                    4'd3: r_hc1 <= t_cord'(w_r16);
                    4'd4: begin
                        r_c3  <= w_c3.val;
                        r_sat <= r_sat | w_c3.sat;
                    end
                    4'd5: begin
                        r_c4  <= w_c4.val;
                        r_sat <= r_sat | w_c4.sat;
                    end
                    4'd6: begin
                        r_hvk <= p_w[65:0];
                        r_c2  <= w_c2.val;
                    end
                    4'd7: begin
                        r_v1  <= w_v1.val;
                        r_sat <= r_sat | w_v1.sat;
                    end
                    4'd8: begin
                        r_th1 <= w_th1.val;
                        r_sat <= r_sat | w_th1.sat;
                    end
                    default: ;
                endcase
            end
            S_REDUCE: begin
                if (r_op == 4'd0) begin
                    r_q <= w_q[8:0];
                end else begin
                    r_z  <= t_cord'(w_z);
                    r_cx <= CORDIC_GAIN_Q30;
                    r_sy <= '0;
                end
            end
            S_ROTATE: begin
                if (!r_z[33]) begin
                    r_cx <= r_cx - ys;
                    r_sy <= r_sy + xs;
                    r_z  <= r_z - atan_i;
                end else begin
                    r_cx <= r_cx + ys;
                    r_sy <= r_sy - xs;
                    r_z  <= r_z + atan_i;
                end
            end
            S_QUAD: begin
                if (!r_sel) begin
                    r_cth <= q_cos;
                    r_sth <= q_sin;
                end else begin
                    r_cc2 <= q_cos;
                    r_sc2 <= q_sin;
                end
            end
            S_PROJECT: begin
                case (r_op)
                    4'd0, 4'd2: r_acc <= p_w[65:0];
                    4'd1: begin
                        r_x1  <= w_x1.val;
                        r_sat <= r_sat | w_x1.sat;
                    end
                    4'd3: begin
                        r_y1  <= w_y1.val;
                        r_sat <= r_sat | w_y1.sat;
                    end
                    default: ;
                endcase
            end
            default: ;
        endcase
        // Load the output register
        if (commit) begin
            r_o_px  <= r_x1;
            r_o_py  <= r_y1;
            r_o_th  <= r_th1;
            r_o_v   <= r_v1;
            r_o_a   <= r_c4;
            r_o_k   <= r_c3;
            r_o_sat <= r_sat;
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.next_pos_x     = r_o_px;
    assign o_out.next_pos_y     = r_o_py;
    assign o_out.next_heading   = r_o_th;
    assign o_out.next_speed     = r_o_v;
    assign o_out.next_accel     = r_o_a;
    assign o_out.next_curvature = r_o_k;
    assign o_out.saturated      = r_o_sat;

endmodule

@@ sv/kvr_checker.sv @@
// Port-level checks of the rollout core, attached by bind.
// Depends on kinematic_vehicle_rollout_core and the channel interfaces.
module kvr_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic i_in_ready,
    input logic i_out_valid,
    input logic i_out_ready,
    input logic i_cfg_ready
);

    // Hold a result transaction until it is taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped before being taken");

    // Drop ready once a step transaction is accepted
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("second step accepted while busy");

    // A new result only appears at the end of a step, never straight after acceptance
    a_no_early: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> !$past(i_in_ready) && !$past(i_in_valid && i_in_ready))
        else $error("result raised without a step in flight");

    // Configuration writes are always taken
    a_cfg_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_ready)
        else $error("configuration port stalled");

endmodule

bind kinematic_vehicle_rollout_core kvr_checker u_kvr_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_cfg_ready (i_cfg.ready)
);
